>>> rtl/uv_sphere_vertex_generator_top_macros.svh
// assertion macros for the uv sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define UVS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uvs assertion failed");

// next-cycle implication
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uvs assertion failed");

`endif

>>> rtl/uvs_pkg.sv
// package: types, constants and tables of the uv sphere vertex generator
package uvs_pkg;

	localparam int MAX_SLICES_DEF    = 256;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MIN_SLICES        = 4;
	localparam int IDX_W             = 9;
	localparam int BAND_W            = 7;
	localparam int ANG_W             = 32;
	localparam int TRIG_W            = 32;
	localparam int TEX_W             = 17;
	localparam int POS_W             = 32;
	localparam int NRM_W             = 16;
	localparam int RAD_W             = 24;
	localparam int SLC_W             = 9;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 32;
	localparam int QUEUE_DEPTH       = 4;
	localparam int Q0_W              = 31;
	localparam int P_W               = IDX_W + Q0_W;
	localparam int DIV_STEPS         = 33;
	localparam int CNT_W             = 6;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = 32'sd652032874;
	localparam logic [ANG_W-1:0]         QUARTER_TURN = 32'h4000_0000;
	localparam logic [TEX_W-1:0]         TEX_ONE      = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z,
		REG_RADIUS,
		REG_SLICES
	} cfg_reg_t;

	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [IDX_W-1:0]  column;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic [TEX_W-1:0]        tex_u;
		logic [TEX_W-1:0]        tex_v;
		logic                    is_last;
		logic                    bad_index;
	} vertex_t;

	// carried alongside the longitude rotation
	typedef struct packed {
		logic [ANG_W-1:0] ang_hi;
		logic [ANG_W-1:0] ang_lo;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v_hi;
		logic [TEX_W-1:0] tex_v_lo;
		logic             bad;
	} fsb_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] clon;
		logic signed [TRIG_W-1:0] slon;
		fsb_t                     sb;
	} qent_t;

	// carried alongside the latitude rotation
	typedef struct packed {
		logic signed [TRIG_W-1:0] clon;
		logic signed [TRIG_W-1:0] slon;
		logic [TEX_W-1:0]         tex_u;
		logic [TEX_W-1:0]         tex_v;
		logic                     is_last;
		logic                     bad;
	} bsb_t;

	// arctangent of 2^-i in 2^-32 turn units
	function automatic logic [ANG_W-1:0] atan_turn(input int i);
		logic [ANG_W-1:0] a;
		case (i)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/uv_sphere_vertex_generator_top.sv
// throughput: one vertex per cycle while not stalled, set by the shared latitude cordic
// reset: config registers to their defaults; a serial divide of one turn by the
// slice count runs after reset and after every slice_count write, item_ready low meanwhile
// top level of the uv sphere vertex generator: config registers and block wiring
module uv_sphere_vertex_generator_top import uvs_pkg::*; #(
	parameter int MAX_SLICES    = MAX_SLICES_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  vertex_valid,
	input  logic                  vertex_ready,
	output vertex_t               vertex,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NW = $clog2(MAX_SLICES + 1);
	localparam int S  = IDX_W + 2 * NW;
	localparam int MW = S - 1;

	logic signed [POS_W-1:0] cx_q, cy_q, cz_q;
	logic [RAD_W-1:0]        rad_q;
	logic [SLC_W-1:0]        slc_q;
	logic                    start_q;
	logic                    wr;
	logic [NW-1:0]           n;

	logic            busy;
	logic [Q0_W-1:0] q0;
	logic [NW-1:0]   r0;
	logic [MW-1:0]   m;

	logic  push, pop, full, empty;
	qent_t push_data, head;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
			rad_q   <= RAD_W'(65536);
			slc_q   <= SLC_W'(16);
			start_q <= 1'b0;
		end else begin
			start_q <= wr && (cfg_index == REG_SLICES);
			if (wr) begin
				case (cfg_index)
					REG_CENTER_X: cx_q  <= cfg_data;
					REG_CENTER_Y: cy_q  <= cfg_data;
					REG_CENTER_Z: cz_q  <= cfg_data;
					REG_RADIUS:   rad_q <= cfg_data[RAD_W-1:0];
					REG_SLICES:   slc_q <= cfg_data[SLC_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		if (32'(slc_q) < MIN_SLICES)
			n = NW'(MIN_SLICES);
		else if (32'(slc_q) > MAX_SLICES)
			n = NW'(MAX_SLICES);
		else
			n = NW'(slc_q);
	end

	uvs_recip #(
		.MAX_SLICES(MAX_SLICES)
	) u_recip (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.n     (n),
		.busy  (busy),
		.q0    (q0),
		.r0    (r0),
		.m     (m)
	);

	uvs_front #(
		.MAX_SLICES   (MAX_SLICES),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.n         (n),
		.busy      (busy || start_q),
		.q0        (q0),
		.r0        (r0),
		.m         (m),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	uvs_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH($bits(qent_t))
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (head),
		.empty    (empty)
	);

	uvs_back #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.vertex_valid(vertex_valid),
		.vertex_ready(vertex_ready),
		.vertex      (vertex),
		.cx          (cx_q),
		.cy          (cy_q),
		.cz          (cz_q),
		.radius      (rad_q)
	);

endmodule

>>> rtl/uvs_recip.sv
// serial divider forming the turn-per-slice constants for the current slice count
module uvs_recip import uvs_pkg::*; #(
	parameter int MAX_SLICES = MAX_SLICES_DEF,
	localparam int NW = $clog2(MAX_SLICES + 1),
	localparam int S  = IDX_W + 2 * NW,
	localparam int MW = S - 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   n,
	output logic            busy,
	output logic [Q0_W-1:0] q0,
	output logic [NW-1:0]   r0,
	output logic [MW-1:0]   m
);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NW-1:0]        rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [NW:0]          rem_sh;
	logic                 ge;
	logic [NW:0]          rem_nx;
	logic                 pow2;

	assign rem_sh = {rem_q, cnt_q == '0};
	assign ge     = rem_sh >= {1'b0, n};
	assign rem_nx = ge ? rem_sh - {1'b0, n} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q != CNT_W'(DIV_STEPS)) begin
				rem_q <= rem_nx[NW-1:0];
				cnt_q <= cnt_q + 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start && cnt_q != CNT_W'(DIV_STEPS))
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
	end

	assign pow2 = (n & (n - 1'b1)) == '0;
	assign busy = busy_q;
	assign q0   = quo_q[Q0_W-1:0];
	assign r0   = rem_q;
	assign m    = MW'(quo_q[Q0_W-1:0] >> (32 - S)) + MW'(!pow2);

endmodule

>>> rtl/uvs_cordic.sv
// pipelined rotation-mode cordic giving cosine and sine of a turn fraction
module uvs_cordic import uvs_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int SB_W   = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [ANG_W-1:0]         angle,
	input  logic [SB_W-1:0]          in_sb,
	output logic                     out_valid,
	output logic signed [TRIG_W-1:0] cos_v,
	output logic signed [TRIG_W-1:0] sin_v,
	output logic [SB_W-1:0]          out_sb
);

	logic signed [TRIG_W-1:0] x_s [STAGES+1];
	logic signed [TRIG_W-1:0] y_s [STAGES+1];
	logic signed [ANG_W:0]    z_s [STAGES+1];
	logic                     flip_s [STAGES+1];
	logic                     v_s [STAGES+1];
	logic [SB_W-1:0]          sb_s [STAGES+1];

	logic signed [ANG_W:0] z_in;
	logic signed [ANG_W:0] z_fold;
	logic                  flip_in;

	assign z_in = (ANG_W+1)'($signed(angle));

	always_comb begin
		z_fold  = z_in;
		flip_in = 1'b0;
		if (z_in > 33'sd1073741824) begin
			z_fold  = z_in - 33'sd2147483648;
			flip_in = 1'b1;
		end else if (z_in < -33'sd1073741824) begin
			z_fold  = z_in + 33'sd2147483648;
			flip_in = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= z_fold;
			flip_s[0] <= flip_in;
			sb_s[0]   <= in_sb;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam logic signed [ANG_W:0] A = (ANG_W+1)'(atan_turn(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ANG_W]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - A;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + A;
				end
				flip_s[i+1] <= flip_s[i];
				sb_s[i+1]   <= sb_s[i];
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign cos_v     = flip_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
	assign sin_v     = flip_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
	assign out_sb    = sb_s[STAGES];

endmodule

>>> rtl/uvs_front.sv
// front end: takes index pairs, forms phases and texture coordinates, rotates longitude
module uvs_front import uvs_pkg::*; #(
	parameter int MAX_SLICES    = MAX_SLICES_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	localparam int NW = $clog2(MAX_SLICES + 1),
	localparam int S  = IDX_W + 2 * NW,
	localparam int MW = S - 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  item_t           item,
	input  logic [NW-1:0]   n,
	input  logic            busy,
	input  logic [Q0_W-1:0] q0,
	input  logic [NW-1:0]   r0,
	input  logic [MW-1:0]   m,
	output logic            push,
	output qent_t           push_data,
	input  logic            full
);

	localparam int XW = IDX_W + NW;

	function automatic logic [TEX_W-1:0] tex_sat(input logic [P_W-1:0] v);
		return (v > P_W'(TEX_ONE)) ? TEX_ONE : v[TEX_W-1:0];
	endfunction

	logic en;
	logic accept;
	logic bad_in;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0] col_s1, hi_s1, lo_s1;
	logic             bad_s1, bad_s2, bad_s3;
	logic [P_W-1:0]   ac_s2, ah_s2, al_s2;
	logic [XW-1:0]    xc_s2, xh_s2, xl_s2;
	logic [P_W-1:0]   ac_s3, ah_s3, al_s3;
	logic [IDX_W-1:0] dc_s3, dh_s3, dl_s3;
	logic [ANG_W-1:0] ang_s4;
	fsb_t             sb_s4;

	logic [XW+MW-1:0] yc, yh, yl;
	logic [P_W-1:0]   pc, ph, pl;

	logic                     cv;
	logic signed [TRIG_W-1:0] clon, slon;
	fsb_t                     csb;

	assign en         = !cv || !full;
	assign item_ready = en && !busy;
	assign accept     = item_valid && item_ready;
	assign bad_in     = (32'(item.band) >= 32'(n >> 1)) || (32'(item.column) > 32'(n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign yc = (XW+MW)'(xc_s2) * (XW+MW)'(m);
	assign yh = (XW+MW)'(xh_s2) * (XW+MW)'(m);
	assign yl = (XW+MW)'(xl_s2) * (XW+MW)'(m);

	assign pc = ac_s3 + P_W'(dc_s3);
	assign ph = ah_s3 + P_W'(dh_s3);
	assign pl = al_s3 + P_W'(dl_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= item.column;
			hi_s1  <= IDX_W'(item.band) + 1'b1;
			lo_s1  <= IDX_W'(item.band);
			bad_s1 <= bad_in;

			ac_s2  <= P_W'(col_s1) * P_W'(q0);
			ah_s2  <= P_W'(hi_s1) * P_W'(q0);
			al_s2  <= P_W'(lo_s1) * P_W'(q0);
			xc_s2  <= XW'(col_s1) * XW'(r0);
			xh_s2  <= XW'(hi_s1) * XW'(r0);
			xl_s2  <= XW'(lo_s1) * XW'(r0);
			bad_s2 <= bad_s1;

			ac_s3  <= ac_s2;
			ah_s3  <= ah_s2;
			al_s3  <= al_s2;
			dc_s3  <= IDX_W'(yc >> S);
			dh_s3  <= IDX_W'(yh >> S);
			dl_s3  <= IDX_W'(yl >> S);
			bad_s3 <= bad_s2;

			ang_s4         <= pc[ANG_W-1:0];
			sb_s4.ang_hi   <= ph[ANG_W-1:0] - QUARTER_TURN;
			sb_s4.ang_lo   <= pl[ANG_W-1:0] - QUARTER_TURN;
			sb_s4.tex_u    <= tex_sat(pc >> 16);
			sb_s4.tex_v_hi <= tex_sat(ph >> 15);
			sb_s4.tex_v_lo <= tex_sat(pl >> 15);
			sb_s4.bad      <= bad_s3;
		end
	end

	uvs_cordic #(
		.STAGES(CORDIC_STAGES),
		.SB_W  ($bits(fsb_t))
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.angle    (ang_s4),
		.in_sb    (sb_s4),
		.out_valid(cv),
		.cos_v    (clon),
		.sin_v    (slon),
		.out_sb   (csb)
	);

	assign push           = cv && !full;
	assign push_data.clon = clon;
	assign push_data.slon = slon;
	assign push_data.sb   = csb;

endmodule

>>> rtl/uvs_queue.sv
// short fifo between front and back end
module uvs_queue #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

>>> rtl/uvs_back.sv
// back end: issues upper and lower vertex, rotates latitude, forms normals and positions
module uvs_back import uvs_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qent_t                    head,
	input  logic                     empty,
	output logic                     pop,
	output logic                     vertex_valid,
	input  logic                     vertex_ready,
	output vertex_t                  vertex,
	input  logic signed [POS_W-1:0]  cx,
	input  logic signed [POS_W-1:0]  cy,
	input  logic signed [POS_W-1:0]  cz,
	input  logic [RAD_W-1:0]         radius
);

	localparam int PR_W = RAD_W + 1 + TRIG_W;

	function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = (v + 64'sd536870912) >>> 30;
		return t[TRIG_W-1:0];
	endfunction

	function automatic logic signed [NRM_W-1:0] nrm(input logic signed [TRIG_W-1:0] c);
		logic signed [TRIG_W:0] t;
		t = ((TRIG_W+1)'(c) + 33'sd16384) >>> 15;
		if (t > 33'sd32767)
			return 16'sh7fff;
		else if (t < -33'sd32768)
			return 16'sh8000;
		else
			return t[NRM_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] pos(input logic signed [POS_W-1:0] c,
		input logic signed [PR_W-1:0] p);
		logic signed [PR_W-1:0]  t;
		logic signed [POS_W+1:0] s;
		t = (p + PR_W'(64'sd536870912)) >>> 30;
		s = (POS_W+2)'(c) + (POS_W+2)'(t);
		if (s > 34'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -34'sd2147483648)
			return 32'sh80000000;
		else
			return s[POS_W-1:0];
	endfunction

	logic  en;
	logic  sel_q;
	bsb_t  isb;

	logic                     cv;
	logic signed [TRIG_W-1:0] clat, slat;
	bsb_t                     csb;

	logic                     v_s1, v_s2, v_s3;
	logic signed [63:0]       p0_s1, p2_s1;
	logic signed [TRIG_W-1:0] slat_s1;
	bsb_t                     sb_s1, sb_s2, sb_s3;
	logic signed [TRIG_W-1:0] c0_s2, c1_s2, c2_s2;
	logic signed [PR_W-1:0]   r0_s3, r1_s3, r2_s3;
	logic signed [NRM_W-1:0]  n0_s3, n1_s3, n2_s3;
	logic                     vvalid_q;
	vertex_t                  vertex_q;

	assign en  = !vvalid_q || vertex_ready;
	assign pop = en && !empty && sel_q;

	assign isb.clon    = head.clon;
	assign isb.slon    = head.slon;
	assign isb.tex_u   = head.sb.tex_u;
	assign isb.tex_v   = sel_q ? head.sb.tex_v_lo : head.sb.tex_v_hi;
	assign isb.is_last = sel_q;
	assign isb.bad     = head.sb.bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 1'b0;
		else if (en && !empty)
			sel_q <= !sel_q;
	end

	uvs_cordic #(
		.STAGES(CORDIC_STAGES),
		.SB_W  ($bits(bsb_t))
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (!empty),
		.angle    (sel_q ? head.sb.ang_lo : head.sb.ang_hi),
		.in_sb    (isb),
		.out_valid(cv),
		.cos_v    (clat),
		.sin_v    (slat),
		.out_sb   (csb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			vvalid_q <= 1'b0;
		end else if (en) begin
			v_s1     <= cv;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			vvalid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= clat * csb.clon;
			p2_s1   <= clat * csb.slon;
			slat_s1 <= slat;
			sb_s1   <= csb;

			c0_s2 <= rnd30(p0_s1);
			c1_s2 <= slat_s1;
			c2_s2 <= rnd30(p2_s1);
			sb_s2 <= sb_s1;

			r0_s3 <= $signed({1'b0, radius}) * c0_s2;
			r1_s3 <= $signed({1'b0, radius}) * c1_s2;
			r2_s3 <= $signed({1'b0, radius}) * c2_s2;
			n0_s3 <= nrm(c0_s2);
			n1_s3 <= nrm(c1_s2);
			n2_s3 <= nrm(c2_s2);
			sb_s3 <= sb_s2;

			vertex_q.pos_x     <= pos(cx, r0_s3);
			vertex_q.pos_y     <= pos(cy, r1_s3);
			vertex_q.pos_z     <= pos(cz, r2_s3);
			vertex_q.normal_x  <= n0_s3;
			vertex_q.normal_y  <= n1_s3;
			vertex_q.normal_z  <= n2_s3;
			vertex_q.tex_u     <= sb_s3.tex_u;
			vertex_q.tex_v     <= sb_s3.tex_v;
			vertex_q.is_last   <= sb_s3.is_last;
			vertex_q.bad_index <= sb_s3.bad;
		end
	end

	assign vertex_valid = vvalid_q;
	assign vertex       = vertex_q;

endmodule

>>> rtl/uvs_checker.sv
// port-level checks of the uv sphere vertex generator, bound to the top level
`include "uv_sphere_vertex_generator_top_macros.svh"

module uvs_checker import uvs_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    vertex_valid,
	input logic    vertex_ready,
	input vertex_t vertex
);

	logic [7:0]       pend_q;
	logic             last_q;
	logic [TEX_W-1:0] tex_u_q;
	logic             bad_q;
	logic             ibeat, vbeat;
	logic             vstall;
	logic             shared_ok;

	assign ibeat     = item_valid && item_ready;
	assign vbeat     = vertex_valid && vertex_ready;
	assign vstall    = vertex_valid && !vertex_ready;
	assign shared_ok = vertex.tex_u == tex_u_q && vertex.bad_index == bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			last_q <= 1'b0;
		end else begin
			pend_q <= pend_q + (ibeat ? 8'd2 : 8'd0) - (vbeat ? 8'd1 : 8'd0);
			if (vbeat)
				last_q <= !last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (vbeat && !vertex.is_last) begin
			tex_u_q <= vertex.tex_u;
			bad_q   <= vertex.bad_index;
		end
	end

	`UVS_ASSERT_NEXT(a_vertex_hold, vstall, vertex_valid && $stable(vertex))
	`UVS_ASSERT_NOW(a_no_extra_vertex, vertex_valid, pend_q != 8'd0)
	`UVS_ASSERT_NOW(a_pair_order, vertex_valid, vertex.is_last == last_q)
	`UVS_ASSERT_NOW(a_pair_shared, vertex_valid && vertex.is_last, shared_ok)

endmodule

bind uv_sphere_vertex_generator_top uvs_checker u_chk (.*);

>>> bench/tb_uv_sphere_vertex_generator_top.sv
// testbench for the uv sphere vertex generator: queued beats, own vertex predictor, scoreboard
module tb_uv_sphere_vertex_generator_top;
	import uvs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 84;
	localparam int SETTLE = 2 * CORDIC_STAGES_DEF + 20;
	localparam logic [CFG_IDX_W-1:0] IDX_PAST = CFG_IDX_W'(REG_SLICES) + 1'b1;
	localparam logic [CFG_IDX_W-1:0] IDX_TOP = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic vertex_valid;
	logic vertex_ready = 1'b0;
	vertex_t vertex;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	item_t pending_items[$];
	vertex_t expected_vertices[$];
	int errors = 0;
	int items_sent = 0;
	int vertices_seen = 0;
	bit quiet = 1'b0;

	logic signed [31:0] ctr_x = 0, ctr_y = 0, ctr_z = 0;
	logic [RAD_W-1:0] radius = 24'd65536;
	logic [SLC_W-1:0] slices = 9'd16;

	longint atan_tab[24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	uv_sphere_vertex_generator_top dut (.*);

	always #5 clk = ~clk;

	function automatic int eff_slices();
		int n;
		n = int'(slices);
		if (n < MIN_SLICES)
			n = MIN_SLICES;
		if (n > MAX_SLICES_DEF)
			n = MAX_SLICES_DEF;
		return n;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(ang);
		flip = 1'b0;
		x = 64'sd652032874;
		y = 0;
		if (z >= 64'sh80000000)
			z -= 64'sh100000000;
		if (z > 64'sh40000000) begin
			z -= 64'sh80000000;
			flip = 1'b1;
		end else if (z < -64'sh40000000) begin
			z += 64'sh80000000;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic [31:0] turn_phase(int idx, int n);
		logic [63:0] num;
		num = longint'(idx) << 32;
		return 32'(num / n);
	endfunction

	function automatic logic [TEX_W-1:0] tex_coord(int num, int n);
		longint t;
		t = (longint'(num) << 16) / n;
		return TEX_W'(t > 65536 ? 65536 : t);
	endfunction

	function automatic vertex_t vertex_at(int lat, longint clon, longint slon, int column,
			int n, bit last, bit bad);
		vertex_t v;
		longint clat, slat, pos;
		longint comp[3], ctr[3];
		rotate(turn_phase(lat, n) - QUARTER_TURN, clat, slat);
		comp[0] = rnd_shift(clat * clon, 30);
		comp[1] = slat;
		comp[2] = rnd_shift(clat * slon, 30);
		ctr[0] = ctr_x;
		ctr[1] = ctr_y;
		ctr[2] = ctr_z;
		for (int k = 0; k < 3; k++) begin
			pos = clamp(ctr[k] + rnd_shift(longint'(radius) * comp[k], 30),
				-64'sh80000000, 64'sh7FFFFFFF);
			case (k)
				0: begin
					v.pos_x = 32'(pos);
					v.normal_x = 16'(clamp(rnd_shift(comp[k], 15), -32768, 32767));
				end
				1: begin
					v.pos_y = 32'(pos);
					v.normal_y = 16'(clamp(rnd_shift(comp[k], 15), -32768, 32767));
				end
				default: begin
					v.pos_z = 32'(pos);
					v.normal_z = 16'(clamp(rnd_shift(comp[k], 15), -32768, 32767));
				end
			endcase
		end
		v.tex_u = tex_coord(column, n);
		v.tex_v = tex_coord(2 * lat, n);
		v.is_last = last;
		v.bad_index = bad;
		return v;
	endfunction

	task automatic predict_pair(item_t it);
		int n;
		longint clon, slon;
		bit bad;
		n = eff_slices();
		bad = (int'(it.band) >= n / 2) || (int'(it.column) > n);
		rotate(turn_phase(it.column, n), clon, slon);
		expected_vertices.push_back(vertex_at(it.band + 1, clon, slon, it.column, n, 1'b0, bad));
		expected_vertices.push_back(vertex_at(it.band, clon, slon, it.column, n, 1'b1, bad));
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				predict_pair(item);
				items_sent++;
			end
			if (!item_valid || item_ready) begin
				if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// vertex monitor
	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			vertex_ready <= 1'b0;
		end else begin
			if (vertex_valid && vertex_ready) begin
				vertices_seen++;
				if (expected_vertices.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected vertex beat %p", vertex);
				end else begin
					want = expected_vertices.pop_front();
					if (vertex !== want) begin
						errors++;
						if (errors <= 10)
							$display("vertex mismatch\n  exp %p\n  got %p", want, vertex);
					end
				end
			end
			vertex_ready <= quiet || $urandom_range(99) >= 14;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CENTER_X: ctr_x = data;
			REG_CENTER_Y: ctr_y = data;
			REG_CENTER_Z: ctr_z = data;
			REG_RADIUS: radius = data[RAD_W-1:0];
			REG_SLICES: slices = data[SLC_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !item_valid && expected_vertices.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic item_t random_item();
		item_t it;
		int n;
		n = eff_slices();
		if ($urandom_range(99) < 15) begin
			it.band = BAND_W'($urandom_range(127));
			it.column = IDX_W'($urandom_range(511));
		end else begin
			it.band = BAND_W'($urandom_range(n / 2 - 1));
			it.column = IDX_W'($urandom_range(n));
		end
		return it;
	endfunction

	task automatic configure(int ph);
		logic [31:0] cx, cy, cz, rad, slc;
		cx = $urandom;
		cy = $urandom;
		cz = $urandom;
		rad = $urandom;
		slc = $urandom_range(4, 256);
		case (ph)
			1: begin
				cx = 32'h7FFF_FFFF;
				cy = 32'h8000_0000;
				cz = 0;
				rad = 32'h00FF_FFFF;
				slc = 4;
			end
			2: begin
				cx = 0;
				cy = 0;
				cz = 0;
				rad = 0;
				slc = 256;
			end
			3: begin
				rad = 1;
				slc = 0;
			end
			4: slc = 511;
			5: begin
				slc = 3;
				write_reg(IDX_PAST, $urandom);
			end
			6: rad = 32'h0001_0000;
			default: write_reg(IDX_TOP, $urandom);
		endcase
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_SLICES, slc);
	endtask

	initial begin
		int bands[12];
		int cols[12];
		item_t it;
		bands = '{0, 7, 0, 7, 8, 0, 127, 127, 3, 6, 5, 1};
		cols = '{0, 16, 8, 0, 0, 17, 511, 0, 4, 12, 15, 1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 12; i++) begin
			it.band = BAND_W'(bands[i]);
			it.column = IDX_W'(cols[i]);
			pending_items.push_back(it);
		end
		drain();
		for (int ph = 1; ph < PHASES; ph++) begin
			configure(ph);
			quiet = (ph == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pending_items.push_back(random_item());
				if (ph == 4 && i == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end
		$display("%0d index pairs over %0d register settings, %0d vertices checked",
			items_sent, PHASES, vertices_seen);
		$display("mismatches: %0d", errors);
		if (errors == 0 && expected_vertices.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/uvs_pkg.sv
rtl/uvs_recip.sv
rtl/uvs_cordic.sv
rtl/uvs_front.sv
rtl/uvs_queue.sv
rtl/uvs_back.sv
rtl/uv_sphere_vertex_generator_top.sv
rtl/uvs_checker.sv
bench/tb_uv_sphere_vertex_generator_top.sv
